### src/grid_surface_tessellator_assert.svh
// Assertion macros shared by the grid tessellator RTL.
// Each macro expects signals named clk and rst in the including scope.
`ifndef GRID_SURFACE_TESSELLATOR_ASSERT_SVH
`define GRID_SURFACE_TESSELLATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GST_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/gst_pkg.sv
// Shared types, constants and helpers for the grid surface tessellator.
// Used by the front end, the queue, the back end and the top level.
package gst_pkg;

  localparam int MAX_SPLITS = 255;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W     = $clog2(QDEPTH + 1);
  localparam int DIV_STEPS  = 32;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int OUT_DATA_W = 152;
  localparam int LAST_PHASE = 6;

  typedef enum logic [1:0] {
    REG_HALF_WIDTH,
    REG_HALF_HEIGHT,
    REG_COL_SPLITS,
    REG_ROW_SPLITS
  } reg_idx_t;

  typedef struct packed {
    logic [30:0] half_width;
    logic [30:0] half_height;
    logic [7:0]  col_splits;
    logic [7:0]  row_splits;
  } cfg_t;

  // One accepted vertex as handed from the front end to the back end.
  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [16:0] tex_u;
    logic [16:0] tex_v;
    logic [16:0] top_left;
    logic [16:0] bot_left;
    logic        has_tri;
    logic        mesh_end;
  } entry_t;

  function automatic logic [7:0] eff_splits(input logic [7:0] s);
    logic [10:0] wide;
    wide = {3'b000, s};
    if (wide > 11'(MAX_SPLITS)) begin
      return MAX_SPLITS[7:0];
    end
    return s;
  endfunction

endpackage

### src/gst_queue.sv
// Short request queue between the tessellator front end and back end.
// Depends on gst_pkg for the entry type and the queue depth.
module gst_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  gst_pkg::entry_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output gst_pkg::entry_t head_data
);
  import gst_pkg::*;

  entry_t              slots [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign full       = (count == QCNT_W'(QDEPTH));
  assign head_valid = (count != '0);
  assign head_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### src/gst_front.sv
// Front end of the tessellator: accepts heights, tracks the grid walk and
// divides the per-mesh steps. Depends on gst_pkg; feeds gst_queue.
module gst_front (
  input  logic            clk,
  input  logic            rst,
  input  gst_pkg::cfg_t   cfg,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [31:0]     in_height,
  output logic            push,
  output gst_pkg::entry_t push_data,
  input  logic            q_full
);
  import gst_pkg::*;

  typedef enum logic [1:0] {F_RUN, F_DIV, F_FIRST} fstate_t;

  fstate_t              state;
  logic                 started;
  logic [8:0]           col_cnt;
  logic [8:0]           row_cnt;
  logic [31:0]          x_acc;
  logic [31:0]          y_acc;
  logic [16:0]          u_acc;
  logic [16:0]          v_acc;
  logic [31:0]          z_hold;
  logic [DIV_CNT_W-1:0] div_cnt;

  // Four restoring dividers in lockstep: x, y, u and v steps.
  logic [31:0] num      [4];
  logic [31:0] quo      [4];
  logic [9:0]  rem      [4];
  logic [31:0] num_next [4];
  logic [31:0] quo_next [4];
  logic [9:0]  rem_next [4];
  logic [8:0]  divisor  [4];

  logic [7:0]  cs;
  logic [7:0]  rs;
  logic [8:0]  last_col;
  logic [8:0]  last_row;
  logic [8:0]  width_v;
  logic [17:0] row_base;
  logic        row_end;
  logic        mesh_end;
  logic        accept;

  assign cs       = eff_splits(cfg.col_splits);
  assign rs       = eff_splits(cfg.row_splits);
  assign last_col = {1'b0, cs} + 9'd1;
  assign last_row = {1'b0, rs} + 9'd1;
  assign width_v  = {1'b0, cs} + 9'd2;

  assign divisor[0] = last_col;
  assign divisor[1] = last_row;
  assign divisor[2] = last_col;
  assign divisor[3] = last_row;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      logic [10:0] trial;
      trial = {rem[i], num[i][31]};
      if (trial >= {2'b00, divisor[i]}) begin
        rem_next[i] = 10'(trial - {2'b00, divisor[i]});
        quo_next[i] = {quo[i][30:0], 1'b1};
      end else begin
        rem_next[i] = trial[9:0];
        quo_next[i] = {quo[i][30:0], 1'b0};
      end
      num_next[i] = {num[i][30:0], 1'b0};
    end
  end

  assign in_ready = (state == F_RUN) && !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = (accept && started) || ((state == F_FIRST) && !q_full);

  assign row_end  = (col_cnt >= last_col);
  assign mesh_end = row_end && (row_cnt >= last_row);
  assign row_base = {9'd0, width_v} * {9'd0, row_cnt - 9'd1};

  always_comb begin
    push_data.pos_x    = x_acc;
    push_data.pos_y    = y_acc;
    push_data.pos_z    = (state == F_FIRST) ? z_hold : in_height;
    push_data.tex_u    = u_acc;
    push_data.tex_v    = v_acc;
    push_data.top_left = 17'(row_base + {9'd0, col_cnt - 9'd1});
    push_data.bot_left = 17'(row_base + {9'd0, col_cnt - 9'd1} + {9'd0, width_v});
    push_data.has_tri  = (col_cnt != '0) && (row_cnt != '0);
    push_data.mesh_end = mesh_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= F_RUN;
      started <= 1'b0;
      col_cnt <= '0;
      row_cnt <= '0;
      x_acc   <= '0;
      y_acc   <= '0;
      u_acc   <= '0;
      v_acc   <= '0;
      div_cnt <= '0;
      for (int i = 0; i < 4; i++) begin
        quo[i] <= '0;
      end
    end else begin
      case (state)
        F_RUN: begin
          if (accept && !started) begin
            // A new mesh: latch the height and start dividing the steps.
            z_hold  <= in_height;
            x_acc   <= 32'd0 - {1'b0, cfg.half_width};
            y_acc   <= {1'b0, cfg.half_height};
            u_acc   <= '0;
            v_acc   <= '0;
            col_cnt <= '0;
            row_cnt <= '0;
            started <= 1'b1;
            div_cnt <= '0;
            num[0]  <= {cfg.half_width, 1'b0};
            num[1]  <= {cfg.half_height, 1'b0};
            num[2]  <= 32'd65536;
            num[3]  <= 32'd65536;
            for (int i = 0; i < 4; i++) begin
              quo[i] <= '0;
              rem[i] <= '0;
            end
            state <= F_DIV;
          end
        end
        F_DIV: begin
          for (int i = 0; i < 4; i++) begin
            num[i] <= num_next[i];
            quo[i] <= quo_next[i];
            rem[i] <= rem_next[i];
          end
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
            state <= F_FIRST;
          end
        end
        F_FIRST: begin
          if (!q_full) begin
            state <= F_RUN;
          end
        end
        default: begin
          state <= F_RUN;
        end
      endcase

      if (push) begin
        if (row_end) begin
          col_cnt <= '0;
          x_acc   <= 32'd0 - {1'b0, cfg.half_width};
          u_acc   <= '0;
          if (mesh_end) begin
            started <= 1'b0;
          end else begin
            row_cnt <= row_cnt + 1'b1;
            y_acc   <= y_acc - quo[1];
            v_acc   <= v_acc + quo[3][16:0];
          end
        end else begin
          col_cnt <= col_cnt + 1'b1;
          x_acc   <= x_acc + quo[0];
          u_acc   <= u_acc + quo[2][16:0];
        end
      end
    end
  end

endmodule

### src/gst_back.sv
// Back end of the tessellator: expands one queued vertex into its vertex
// result and up to six triangle corners. Depends on gst_pkg; fed by gst_queue.
module gst_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             q_valid,
  input  gst_pkg::entry_t                  q_data,
  output logic                             pop,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [gst_pkg::OUT_DATA_W-1:0]   out_data,
  output logic [1:0]                       out_user,
  output logic                             out_last
);
  import gst_pkg::*;

  entry_t      cur;
  logic        cur_valid;
  logic [2:0]  phase;
  logic        emit;
  logic        finishing;
  logic [16:0] corner;

  assign emit      = cur_valid && (!out_valid || out_ready);
  assign finishing = emit && ((phase == 3'(LAST_PHASE)) || ((phase == 3'd0) && !cur.has_tri));
  assign pop       = q_valid && (!cur_valid || finishing);

  // Corner order: top left, bottom left, top right, bottom left, bottom right, top right.
  always_comb begin
    case (phase)
      3'd1:    corner = cur.top_left;
      3'd2:    corner = cur.bot_left;
      3'd3:    corner = cur.top_left + 17'd1;
      3'd4:    corner = cur.bot_left;
      3'd5:    corner = cur.bot_left + 17'd1;
      3'd6:    corner = cur.top_left + 17'd1;
      default: corner = '0;
    endcase
  end

  // The phase is zero whenever no request is held, so a new one starts there.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      phase     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
        if (phase == 3'd0) begin
          out_data    <= {5'd0, 17'd0, cur.tex_v, cur.tex_u,
                          cur.pos_z, cur.pos_y, cur.pos_x};
          out_user[0] <= 1'b0;
          out_user[1] <= !cur.has_tri;
          out_last    <= !cur.has_tri && cur.mesh_end;
        end else begin
          out_data    <= {5'd0, corner, 130'd0};
          out_user[0] <= 1'b1;
          out_user[1] <= (phase == 3'(LAST_PHASE));
          out_last    <= (phase == 3'(LAST_PHASE)) && cur.mesh_end;
        end
        phase <= finishing ? 3'd0 : phase + 3'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (pop) begin
        cur       <= q_data;
        cur_valid <= 1'b1;
      end else if (finishing) begin
        cur_valid <= 1'b0;
      end
    end
  end

endmodule

### src/grid_surface_tessellator.sv
// Grid surface tessellator: one height in, one vertex plus up to six indices out.
// An accepted height is registered in the queue, then in the back end's held entry and then
// in the output register; a height that closes a cell gives seven results, one per cycle
// while the receiver is ready. The first vertex of each mesh waits while a bit-serial
// divider forms the grid steps. Synchronous reset clears counters, the queue and
// handshakes; configuration returns to half sizes of one and no splits.
module grid_surface_tessellator (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [30:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [31:0]  s_tdata,   // [31:0] height
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [151:0] m_tdata,   // pos_x, pos_y, pos_z, tex_u, tex_v, index_value, pad
  output logic [1:0]   m_tuser,   // [0] is_index, [1] last_of_item
  output logic         m_tlast    // last_of_mesh
);
  import gst_pkg::*;

  cfg_t   cfg;
  logic   q_push;
  entry_t q_push_data;
  logic   q_full;
  logic   q_pop;
  logic   q_valid;
  entry_t q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.half_width  <= 31'd65536;
      cfg.half_height <= 31'd65536;
      cfg.col_splits  <= '0;
      cfg.row_splits  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_HALF_WIDTH:  cfg.half_width  <= cfg_data;
        REG_HALF_HEIGHT: cfg.half_height <= cfg_data;
        REG_COL_SPLITS:  cfg.col_splits  <= cfg_data[7:0];
        REG_ROW_SPLITS:  cfg.row_splits  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  gst_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_height (s_tdata),
    .push      (q_push),
    .push_data (q_push_data),
    .q_full    (q_full)
  );

  gst_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_push_data),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_head)
  );

  gst_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (q_head),
    .pop       (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_user  (m_tuser),
    .out_last  (m_tlast)
  );

`include "grid_surface_tessellator_assert.svh"

  `GST_ASSERT_SAME(a_no_overflow, q_push, !q_full, "queue written while full")
  `GST_ASSERT_SAME(a_mesh_end_closes_item, m_tvalid && m_tlast, m_tuser[1],
                   "mesh end on a result that does not close its item")
  `GST_ASSERT_SAME(a_index_clean, m_tvalid && m_tuser[0], m_tdata[129:0] == '0,
                   "index result carries vertex data")
  `GST_ASSERT_NEXT(a_corners_follow, m_tvalid && m_tready && !m_tuser[1],
                   m_tvalid && m_tuser[0], "gap inside a triangle index run")

endmodule

### dv/tb_top.sv
// Self-checking testbench for grid_surface_tessellator: heights go in, and vertex
// and triangle index results are compared against an in-bench model of the mesh walk.
// Depends on gst_pkg for the register codes and the configuration struct.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import gst_pkg::*;

  localparam int TIMEOUT_CYCLES = 300000;
  localparam int HOLD_CYCLES    = 400;
  localparam int MAX_REPORTS    = 40;

  typedef struct packed {
    logic        is_index;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [16:0] tex_u;
    logic [16:0] tex_v;
    logic [16:0] index_value;
    logic        last_item;
    logic        last_mesh;
  } mesh_output_t;

  class grid_mesh_scoreboard;
    cfg_t         regs;
    logic [8:0]   col_cnt, row_cnt;
    logic [31:0]  x_acc, y_acc, x_inc, y_inc;
    logic [16:0]  u_acc, v_acc, u_inc, v_inc;
    bit           in_mesh;
    mesh_output_t mesh_outputs_q[$];
    int           errors;

    function new();
      regs.half_width  = 31'd65536;
      regs.half_height = 31'd65536;
      regs.col_splits  = 8'd0;
      regs.row_splits  = 8'd0;
      col_cnt = '0;
      row_cnt = '0;
      x_acc = '0;
      y_acc = '0;
      x_inc = '0;
      y_inc = '0;
      u_acc = '0;
      v_acc = '0;
      u_inc = '0;
      v_inc = '0;
      in_mesh = 1'b0;
      errors = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [30:0] val);
      case (idx)
        REG_HALF_WIDTH:  regs.half_width  = val;
        REG_HALF_HEIGHT: regs.half_height = val;
        REG_COL_SPLITS:  regs.col_splits  = val[7:0];
        REG_ROW_SPLITS:  regs.row_splits  = val[7:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return mesh_outputs_q.size();
    endfunction

    function void add_expected(mesh_output_t res);
      mesh_outputs_q.insert(mesh_outputs_q.size(), res);
    endfunction

    // Walks one vertex of the grid and queues every result it causes.
    function void note_height(logic [31:0] z);
      logic [8:0]   cs, rs, w;
      logic [31:0]  tl, bl;
      logic [31:0]  corner[6];
      bit           has_tri, row_end, mesh_end;
      mesh_output_t res;
      cs = (int'(regs.col_splits) > MAX_SPLITS) ? 9'(MAX_SPLITS) : {1'b0, regs.col_splits};
      rs = (int'(regs.row_splits) > MAX_SPLITS) ? 9'(MAX_SPLITS) : {1'b0, regs.row_splits};
      w = cs + 9'd2;
      if (!in_mesh) begin
        x_inc = {regs.half_width, 1'b0} / (32'(cs) + 32'd1);
        y_inc = {regs.half_height, 1'b0} / (32'(rs) + 32'd1);
        u_inc = 17'(32'd65536 / (32'(cs) + 32'd1));
        v_inc = 17'(32'd65536 / (32'(rs) + 32'd1));
        x_acc = 32'd0 - {1'b0, regs.half_width};
        y_acc = {1'b0, regs.half_height};
        u_acc = '0;
        v_acc = '0;
        col_cnt = '0;
        row_cnt = '0;
        in_mesh = 1'b1;
      end
      has_tri  = (col_cnt >= 9'd1) && (row_cnt >= 9'd1);
      row_end  = col_cnt >= cs + 9'd1;
      mesh_end = row_end && (row_cnt >= rs + 9'd1);

      res = '0;
      res.pos_x = x_acc;
      res.pos_y = y_acc;
      res.pos_z = z;
      res.tex_u = u_acc;
      res.tex_v = v_acc;
      res.last_item = !has_tri;
      res.last_mesh = mesh_end && !has_tri;
      add_expected(res);

      if (has_tri) begin
        tl = 32'(w) * (32'(row_cnt) - 32'd1) + (32'(col_cnt) - 32'd1);
        bl = 32'(w) * 32'(row_cnt) + (32'(col_cnt) - 32'd1);
        corner = '{tl, bl, tl + 32'd1, bl, bl + 32'd1, tl + 32'd1};
        for (int i = 0; i < 6; i++) begin
          res = '0;
          res.is_index = 1'b1;
          res.index_value = corner[i][16:0];
          res.last_item = (i == 5);
          res.last_mesh = (i == 5) && mesh_end;
          add_expected(res);
        end
      end

      if (row_end) begin
        col_cnt = '0;
        x_acc = 32'd0 - {1'b0, regs.half_width};
        u_acc = '0;
        if (mesh_end) begin
          in_mesh = 1'b0;
        end else begin
          row_cnt = row_cnt + 9'd1;
          y_acc = y_acc - y_inc;
          v_acc = v_acc + v_inc;
        end
      end else begin
        col_cnt = col_cnt + 9'd1;
        x_acc = x_acc + x_inc;
        u_acc = u_acc + u_inc;
      end
    endfunction

    function bit field_ok(string name, logic [31:0] want, logic [31:0] got);
      if (want === got) return 1'b1;
      if (errors < MAX_REPORTS)
        $display("%0t: mismatch on %s: expected %h, actual %h", $time, name, want, got);
      return 1'b0;
    endfunction

    function void check_output(mesh_output_t got);
      mesh_output_t want;
      bit ok;
      if (mesh_outputs_q.size() == 0) begin
        if (errors < MAX_REPORTS)
          $display("%0t: result with nothing expected: actual %p", $time, got);
        errors++;
        return;
      end
      want = mesh_outputs_q.pop_front();
      ok = 1'b1;
      ok &= field_ok("is_index", 32'(want.is_index), 32'(got.is_index));
      ok &= field_ok("pos_x", want.pos_x, got.pos_x);
      ok &= field_ok("pos_y", want.pos_y, got.pos_y);
      ok &= field_ok("pos_z", want.pos_z, got.pos_z);
      ok &= field_ok("tex_u", 32'(want.tex_u), 32'(got.tex_u));
      ok &= field_ok("tex_v", 32'(want.tex_v), 32'(got.tex_v));
      ok &= field_ok("index_value", 32'(want.index_value), 32'(got.index_value));
      ok &= field_ok("last_of_item", 32'(want.last_item), 32'(got.last_item));
      ok &= field_ok("last_of_mesh", 32'(want.last_mesh), 32'(got.last_mesh));
      if (!ok) errors++;
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = '0;
  logic [30:0]  cfg_data = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [31:0]  s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [151:0] m_tdata;
  logic [1:0]   m_tuser;
  logic         m_tlast;

  grid_mesh_scoreboard sb = new();

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int cycle_count = 0;

  grid_surface_tessellator dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) cycle_count++;

  // Receiver: random stalls, plus a long hold-off on request so the block backs up.
  always begin
    @(negedge clk);
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    mesh_output_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.is_index    = m_tuser[0];
      got.pos_x       = m_tdata[31:0];
      got.pos_y       = m_tdata[63:32];
      got.pos_z       = m_tdata[95:64];
      got.tex_u       = m_tdata[112:96];
      got.tex_v       = m_tdata[129:113];
      got.index_value = m_tdata[146:130];
      got.last_item   = m_tuser[1];
      got.last_mesh   = m_tlast;
      sb.check_output(got);
    end
  end

  initial begin
    wait (cycle_count >= TIMEOUT_CYCLES);
    $display("tb_top: FAIL");
    $finish;
  end

  task automatic send_height(input logic [31:0] h);
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= h;
    do @(posedge clk); while (!s_tready);
    sb.note_height(h);
  endtask

  // Stops offering heights and waits until every queued result has come back.
  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [30:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
  endtask

  task automatic set_config(input logic [30:0] hw, input logic [30:0] hh,
                            input logic [7:0] cs, input logic [7:0] rs);
    write_reg(REG_HALF_WIDTH, hw);
    write_reg(REG_HALF_HEIGHT, hh);
    write_reg(REG_COL_SPLITS, {23'd0, cs});
    write_reg(REG_ROW_SPLITS, {23'd0, rs});
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_height();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [30:0] pick_half();
    case ($urandom_range(0, 5))
      0: return 31'd0;
      1: return 31'h7FFF_FFFF;
      2: return 31'($urandom_range(0, 1 << 20));
      default: return 31'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_splits();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll < 16) return 8'($urandom_range(0, 3));
    if (roll < 19) return 8'($urandom_range(0, 255));
    return 8'd255;
  endfunction

  task automatic random_phase(input int n, input int phase);
    int k;
    // Most phases close the running mesh first so the next one starts clean.
    if ($urandom_range(0, 3) != 0) begin
      k = 0;
      while (sb.in_mesh && k < 40) begin
        send_height(pick_height());
        k++;
      end
    end
    wait_idle();
    set_config(pick_half(), pick_half(), pick_splits(), pick_splits());
    if (phase == 2) hold_req = 1'b1;
    for (int i = 0; i < n; i++) begin
      if (phase == 5 && i == n / 2) wait_idle();
      send_height(pick_height());
    end
  endtask

  initial begin
    int guard;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset values give a two by two grid: one cell, extreme heights.
    send_height(32'h8000_0000);
    send_height(32'h7FFF_FFFF);
    send_height(32'h0000_0000);
    send_height(32'hFFFF_FFFF);
    wait_idle();
    set_config(31'h7FFF_FFFF, 31'h7FFF_FFFF, 8'd0, 8'd0);
    repeat (4) send_height($urandom);
    wait_idle();
    set_config(31'd0, 31'd0, 8'd1, 8'd0);
    repeat (6) send_height($urandom);
    wait_idle();

    // Largest split counts at the mesh start, then cut back mid-mesh so the
    // latched steps stay while the live bounds end the row and the mesh early.
    set_config(31'h7FFF_FFFF, 31'h7FFF_FFFF, 8'd255, 8'd255);
    repeat (3) send_height($urandom);
    wait_idle();
    write_reg(REG_COL_SPLITS, 31'd0);
    @(negedge clk);
    cfg_valid <= 1'b0;
    send_height($urandom);
    wait_idle();
    write_reg(REG_ROW_SPLITS, 31'd0);
    @(negedge clk);
    cfg_valid <= 1'b0;
    repeat (2) send_height($urandom);

    for (int p = 0; p < 10; p++) begin
      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 70; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 70; end
        default: begin tx_idle_pct = 25; rx_stall_pct = 25; end
      endcase
      random_phase(18, p);
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    guard = 0;
    while (sb.pending() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
